[hdl/lrt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_pkg
// Shared types, codes and helpers of the lpm route table.
// ---------------------------------------------------------------------------
package lrt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int INTERFACE_COUNT     = 16;

   // operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAME = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   localparam logic [5:0] MAX_LENGTH = 6'd32;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] ip_address;
      logic [5:0]  prefix_length;
      logic        has_gateway;
      logic [31:0] gw_address;
      logic [3:0]  out_interface;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        route_direct;
      logic [31:0] next_hop_gateway;
      logic [3:0]  next_hop_interface;
      logic [5:0]  matched_length;
   } rsp_type;

   // search token walking the row of cells
   typedef struct packed {
      logic        active;
      logic [1:0]  op;
      logic [31:0] addr;
      logic [5:0]  length;
      logic        direct;
      logic [31:0] gateway;
      logic [3:0]  oif;
      logic        exact_hit;
      logic        exact_same;
      logic        free_hit;
      logic        best_hit;
      logic [5:0]  best_length;
      logic        best_direct;
      logic [31:0] best_gateway;
      logic [3:0]  best_oif;
   } tok_type;

   // write broadcast to the cell that claimed the slot
   typedef struct packed {
      logic        en;
      logic        clear;
      logic        to_free;
      logic [31:0] prefix;
      logic [5:0]  length;
      logic        direct;
      logic [31:0] gateway;
      logic [3:0]  oif;
   } wr_type;

   // netmask for a length of 0 to 32
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len >= MAX_LENGTH) begin
         m = 32'hFFFF_FFFF;
      end else begin
         m = ~(32'hFFFF_FFFF >> len[4:0]);
      end
      return m;
   endfunction

   // interface index reduced into range by repeated subtraction
   function automatic logic [3:0] oif_reduce(input logic [3:0] v);
      logic [8:0] r;
      r = {5'd0, v};
      for (int k = 0; k < 8; k++) begin
         if (r >= 9'(INTERFACE_COUNT)) begin
            r = r - 9'(INTERFACE_COUNT);
         end
      end
      return r[3:0];
   endfunction

endpackage

[hdl/lrt_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrt_cell
// One route entry; checks the passing token and hands it to the next cell.
// ---------------------------------------------------------------------------
module lrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  lrt_pkg::tok_type tok_prev,
   input  lrt_pkg::wr_type  wr,
   output lrt_pkg::tok_type tok_out
);

   logic        valid_ff;
   logic [31:0] prefix_ff;
   logic [5:0]  length_ff;
   logic        direct_ff;
   logic [31:0] gateway_ff;
   logic [3:0]  interface_ff;
   logic        claim_exact_ff;
   logic        claim_free_ff;
   lrt_pkg::tok_type tok_ff;
   lrt_pkg::tok_type tok_in;

   logic        match_exact;
   logic        first_exact;
   logic        first_free;
   logic [31:0] mask;
   logic        match_lpm;
   logic        better;
   logic        selected;

   always_comb begin
      mask        = lrt_pkg::prefix_mask(length_ff);
      match_exact = valid_ff && (prefix_ff == tok_prev.addr) && (length_ff == tok_prev.length);
      first_exact = tok_prev.active && !tok_prev.exact_hit && match_exact;
      first_free  = tok_prev.active && !tok_prev.free_hit && !valid_ff;
      match_lpm   = valid_ff && ((prefix_ff & mask) == (tok_prev.addr & mask));
      better      = match_lpm && (tok_prev.op == lrt_pkg::OP_LOOKUP)
                    && (!tok_prev.best_hit || (tok_prev.best_length < length_ff));

      tok_in = tok_prev;
      if (first_exact) begin
         tok_in.exact_hit  = 1'b1;
         tok_in.exact_same = (direct_ff == tok_prev.direct) && (gateway_ff == tok_prev.gateway)
                             && (interface_ff == tok_prev.oif);
      end
      if (first_free) begin
         tok_in.free_hit = 1'b1;
      end
      if (better) begin
         tok_in.best_hit     = 1'b1;
         tok_in.best_length  = length_ff;
         tok_in.best_direct  = direct_ff;
         tok_in.best_gateway = gateway_ff;
         tok_in.best_oif     = interface_ff;
      end
   end

   assign selected = wr.en && (wr.to_free ? claim_free_ff : claim_exact_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         claim_exact_ff <= 1'b0;
         claim_free_ff  <= 1'b0;
         tok_ff.active  <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (tok_prev.active) begin
            claim_exact_ff <= first_exact;
            claim_free_ff  <= first_free;
         end
         if (selected) begin
            valid_ff <= !wr.clear;
         end
      end
   end

   // entry payload, no reset
   always_ff @(posedge clock) begin
      if (selected && !wr.clear) begin
         prefix_ff    <= wr.prefix;
         length_ff    <= wr.length;
         direct_ff    <= wr.direct;
         gateway_ff   <= wr.gateway;
         interface_ff <= wr.oif;
      end
   end

   assign tok_out = tok_ff;

endmodule

[hdl/lpm_route_table_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpm_route_table_unit
// IPv4 route table with add, delete and longest prefix lookup.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result shows on
// rsp_item for one cycle with rsp_strobe high; the receiver cannot stall it.
// A search token walks the row of entry cells, one cell per cycle, then the
// decision step writes the claimed cell and registers the result. Busy drops
// in the same cycle as the result strobe, so the next item can be taken while
// the strobe is high; no new item is taken while one is in flight. All entries
// are invalid right after reset; no clearing pass is needed.
module lpm_route_table_unit #(
   parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lrt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output lrt_pkg::rsp_type rsp_item
);

   logic             busy_ff;
   logic             rsp_strobe_ff;
   lrt_pkg::rsp_type rsp_ff;
   lrt_pkg::rsp_type rsp_in;
   lrt_pkg::tok_type head_ff;
   lrt_pkg::tok_type head_in;
   lrt_pkg::tok_type tail;
   lrt_pkg::wr_type  wr;
   lrt_pkg::tok_type chain_tok [0:TABLE_DEPTH];

   logic       accept;
   logic [5:0] len_sat;
   logic       direct;

   assign accept = start && !busy_ff;

   // build the token: saturate length, drop gateway data on direct routes,
   // mask the route address for add
   always_comb begin
      len_sat = (req_item.prefix_length > lrt_pkg::MAX_LENGTH) ? lrt_pkg::MAX_LENGTH
                                                              : req_item.prefix_length;
      direct  = !req_item.has_gateway;

      head_in           = '0;
      head_in.active    = accept;
      head_in.op        = req_item.operation;
      head_in.length    = len_sat;
      head_in.direct    = direct;
      head_in.gateway   = direct ? 32'd0 : req_item.gw_address;
      head_in.oif       = direct ? 4'd0 : lrt_pkg::oif_reduce(req_item.out_interface);
      head_in.addr      = (req_item.operation == lrt_pkg::OP_ADD)
                          ? (req_item.ip_address & lrt_pkg::prefix_mask(len_sat))
                          : req_item.ip_address;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
      end else if (accept) begin
         head_ff <= head_in;
      end else begin
         head_ff.active <= 1'b0;
      end
   end

   // row of entry cells
   assign chain_tok[0] = head_ff;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      lrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_prev (chain_tok[k]),
         .wr       (wr),
         .tok_out  (chain_tok[k+1])
      );
   end

   assign tail = chain_tok[TABLE_DEPTH];

   // decision once the token leaves the last cell
   always_comb begin
      wr         = '0;
      wr.prefix  = tail.addr;
      wr.length  = tail.length;
      wr.direct  = tail.direct;
      wr.gateway = tail.gateway;
      wr.oif     = tail.oif;
      rsp_in        = '0;
      rsp_in.status = lrt_pkg::ST_MISS;

      unique case (tail.op)
         lrt_pkg::OP_ADD: begin
            if (tail.exact_hit && tail.exact_same) begin
               rsp_in.status = lrt_pkg::ST_SAME;
            end else if (tail.exact_hit) begin
               // overwrite the matching route
               wr.en         = tail.active;
               rsp_in.status = lrt_pkg::ST_OK;
            end else if (tail.free_hit) begin
               // lowest free slot
               wr.en         = tail.active;
               wr.to_free    = 1'b1;
               rsp_in.status = lrt_pkg::ST_OK;
            end else begin
               rsp_in.status = lrt_pkg::ST_FULL;
            end
         end
         lrt_pkg::OP_DELETE: begin
            if (tail.exact_hit) begin
               wr.en         = tail.active;
               wr.clear      = 1'b1;
               rsp_in.status = lrt_pkg::ST_OK;
            end
         end
         lrt_pkg::OP_LOOKUP: begin
            if (tail.best_hit) begin
               rsp_in.status             = lrt_pkg::ST_OK;
               rsp_in.route_direct       = tail.best_direct;
               rsp_in.next_hop_gateway   = tail.best_gateway;
               rsp_in.next_hop_interface = tail.best_oif;
               rsp_in.matched_length     = tail.best_length;
            end
         end
         default: begin
            // unknown operation: no change, miss
            rsp_in.status = lrt_pkg::ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tail.active;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (tail.active) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (tail.active) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // an accepted item keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("item accepted but unit not busy");

   // a token in the row always belongs to an item in flight
   a_head_busy: assert property (@(posedge clock) disable iff (reset)
      (head_ff.active || tail.active) |-> busy_ff)
      else $error("search token without an item in flight");

   // result only once the unit is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy_ff)
      else $error("result strobe while still busy");

   // one strobe per item
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for two cycles");

endmodule
